// ===== rtl/cmts_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, token class codes and character helpers for the token scanner.
// Used by cmts_scan, cmts_rq and c_minus_token_scanner_unit; no dependencies.
package cmts_pkg;

  // number of leading token characters kept for reserved-word matching
  localparam int KW_CHARS = 6;
  localparam int WC_IDX_W = $clog2(KW_CHARS);
  // result queue depth (two results may arrive per transfer)
  localparam int RQ_DEPTH = 4;

  // token classes
  localparam logic [4:0] CLS_PLUS   = 5'd8;
  localparam logic [4:0] CLS_MINUS  = 5'd9;
  localparam logic [4:0] CLS_STAR   = 5'd10;
  localparam logic [4:0] CLS_SLASH  = 5'd11;
  localparam logic [4:0] CLS_LT     = 5'd12;
  localparam logic [4:0] CLS_GT     = 5'd13;
  localparam logic [4:0] CLS_ASSIGN = 5'd14;
  localparam logic [4:0] CLS_SEMI   = 5'd15;
  localparam logic [4:0] CLS_COMMA  = 5'd16;
  localparam logic [4:0] CLS_LBRK   = 5'd17;
  localparam logic [4:0] CLS_RBRK   = 5'd18;
  localparam logic [4:0] CLS_LPAR   = 5'd19;
  localparam logic [4:0] CLS_RPAR   = 5'd20;
  localparam logic [4:0] CLS_LBRC   = 5'd21;
  localparam logic [4:0] CLS_RBRC   = 5'd22;
  localparam logic [4:0] CLS_LE     = 5'd23;
  localparam logic [4:0] CLS_GE     = 5'd24;
  localparam logic [4:0] CLS_EQ     = 5'd25;
  localparam logic [4:0] CLS_NE     = 5'd26;
  localparam logic [4:0] CLS_ID     = 5'd27;
  localparam logic [4:0] CLS_NUM    = 5'd28;
  localparam logic [4:0] CLS_DBL    = 5'd29;
  localparam logic [4:0] CLS_STR    = 5'd30;
  localparam logic [4:0] CLS_ERR    = 5'd31;

  // reserved words, class equals row index
  localparam logic [7:0] KW_TEXT [8][KW_CHARS] = '{
    '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"e", "l", "s", "e", 8'h00, 8'h00},
    '{"i", "n", "t", 8'h00, 8'h00, 8'h00},
    '{"d", "o", "u", "b", "l", "e"},
    '{"r", "e", "t", "u", "r", "n"},
    '{"v", "o", "i", "d", 8'h00, 8'h00},
    '{"w", "h", "i", "l", "e", 8'h00},
    '{"c", "h", "a", "r", 8'h00, 8'h00}
  };
  localparam logic [2:0] KW_LEN [8] = '{3'd2, 3'd4, 3'd3, 3'd6, 3'd6, 3'd4, 3'd5, 3'd4};

  typedef struct packed {
    logic       kind;
    logic [7:0] byte_value;
  } char_item_t;

  typedef struct packed {
    logic [4:0]  token_class;
    logic [31:0] start_offset;
    logic [7:0]  token_length;
    logic        last;
  } token_item_t;

  // results of one accepted item, handed from scanner to result queue
  typedef struct packed {
    logic [1:0]  count;
    token_item_t first;
    token_item_t second;
  } scan_res_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= "0") && (b <= "9");
  endfunction

  function automatic logic is_letter(input logic [7:0] b);
    return ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z"));
  endfunction

  function automatic logic is_blank(input logic [7:0] b);
    return (b == " ") || (b == 8'h09) || (b == 8'h0a);
  endfunction

  // reserved-word lookup on the stored leading characters
  function automatic logic [4:0] word_class(input logic [KW_CHARS-1:0][7:0] wc,
                                            input logic [7:0] cnt);
    logic [4:0] cls;
    logic       hit;
    cls = CLS_ID;
    for (int k = 7; k >= 0; k--) begin
      hit = (cnt == {5'd0, KW_LEN[k]});
      for (int i = 0; i < KW_CHARS; i++) begin
        if ((i < int'(KW_LEN[k])) && (wc[i] != KW_TEXT[k][i])) begin
          hit = 1'b0;
        end
      end
      if (hit) begin
        cls = 5'(k);
      end
    end
    return cls;
  endfunction

endpackage

// ===== rtl/cmts_scan.sv =====
`timescale 1ns / 1ps
// Scanner state machine: one transition per accepted character item.
// Depends on cmts_pkg; produces up to two results per item for cmts_rq.
module cmts_scan #(
  parameter int MAX_TOKEN_LEN = 255
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  cmts_pkg::char_item_t item,
  output cmts_pkg::scan_res_t  res
);
  import cmts_pkg::*;

  localparam logic [7:0] LEN_CAP = 8'((MAX_TOKEN_LEN < 255) ? MAX_TOKEN_LEN : 255);

  localparam logic [4:0] S_START    = 5'd0;
  localparam logic [4:0] S_PLUS     = 5'd1;
  localparam logic [4:0] S_SLASH    = 5'd2;
  localparam logic [4:0] S_LT       = 5'd3;
  localparam logic [4:0] S_GT       = 5'd4;
  localparam logic [4:0] S_EQ       = 5'd5;
  localparam logic [4:0] S_BANG     = 5'd6;
  localparam logic [4:0] S_STR      = 5'd7;
  localparam logic [4:0] S_ID       = 5'd8;
  localparam logic [4:0] S_INT      = 5'd9;
  localparam logic [4:0] S_FRAC     = 5'd10;
  localparam logic [4:0] S_EXP      = 5'd11;
  localparam logic [4:0] S_EXPSIGN  = 5'd12;
  localparam logic [4:0] S_EXPDIG   = 5'd13;
  localparam logic [4:0] S_LCOM     = 5'd14;
  localparam logic [4:0] S_BCOM     = 5'd15;
  localparam logic [4:0] S_BCOMSTAR = 5'd16;
  localparam logic [4:0] S_SKIP     = 5'd17;

  logic [4:0]                state, state_next;
  logic [31:0]               pos, pos_next;
  logic [31:0]               tstart, tstart_next;
  logic [7:0]                cnt, cnt_next;
  logic [KW_CHARS-1:0][7:0]  wc, wc_next;

  logic [7:0] b;
  logic       dig, blank, term;
  logic [7:0] cnt_add;
  logic       do_add, do_add_emit, do_close, do_restart, pend;
  logic [4:0] cls;
  logic [4:0] start_state;
  logic       is_single;
  logic [4:0] single_cls;
  token_item_t r0, r1;
  logic [1:0]  n;

  assign b     = item.byte_value;
  assign dig   = is_digit(b);
  assign blank = is_blank(b);
  assign term  = blank || (b == ";");
  assign cnt_add = (cnt < LEN_CAP) ? cnt + 8'd1 : cnt;

  // token opened by a character seen in the start state
  always_comb begin
    start_state = S_SKIP;
    is_single   = 1'b0;
    single_cls  = CLS_ERR;
    case (b)
      "+":     start_state = S_PLUS;
      "/":     start_state = S_SLASH;
      "<":     start_state = S_LT;
      ">":     start_state = S_GT;
      "=":     start_state = S_EQ;
      "!":     start_state = S_BANG;
      8'h22:   start_state = S_STR;
      "-":     begin is_single = 1'b1; single_cls = CLS_MINUS; end
      "*":     begin is_single = 1'b1; single_cls = CLS_STAR; end
      ";":     begin is_single = 1'b1; single_cls = CLS_SEMI; end
      ",":     begin is_single = 1'b1; single_cls = CLS_COMMA; end
      "[":     begin is_single = 1'b1; single_cls = CLS_LBRK; end
      "]":     begin is_single = 1'b1; single_cls = CLS_RBRK; end
      "(":     begin is_single = 1'b1; single_cls = CLS_LPAR; end
      ")":     begin is_single = 1'b1; single_cls = CLS_RPAR; end
      "{":     begin is_single = 1'b1; single_cls = CLS_LBRC; end
      "}":     begin is_single = 1'b1; single_cls = CLS_RBRC; end
      default: begin
        if (is_letter(b)) begin
          start_state = S_ID;
        end else if (dig) begin
          start_state = S_INT;
        end
      end
    endcase
  end

  // transition and result building
  always_comb begin
    state_next  = state;
    pos_next    = pos;
    tstart_next = tstart;
    cnt_next    = cnt;
    wc_next     = wc;
    do_add      = 1'b0;
    do_add_emit = 1'b0;
    do_close    = 1'b0;
    do_restart  = 1'b0;
    pend        = 1'b0;
    cls         = CLS_ERR;
    r0          = '0;
    r1          = '0;
    n           = 2'd0;

    if (item.kind) begin
      // end of input: flush the pending token
      case (state)
        S_PLUS:    begin pend = 1'b1; cls = CLS_PLUS; end
        S_SLASH:   begin pend = 1'b1; cls = CLS_SLASH; end
        S_LT:      begin pend = 1'b1; cls = CLS_LT; end
        S_GT:      begin pend = 1'b1; cls = CLS_GT; end
        S_EQ:      begin pend = 1'b1; cls = CLS_ASSIGN; end
        S_ID:      begin pend = 1'b1; cls = word_class(wc, cnt); end
        S_INT:     begin pend = 1'b1; cls = CLS_NUM; end
        S_FRAC,
        S_EXPDIG:  begin pend = 1'b1; cls = CLS_DBL; end
        S_BANG,
        S_STR,
        S_EXP,
        S_EXPSIGN,
        S_SKIP:    begin pend = 1'b1; cls = CLS_ERR; end
        default:   pend = 1'b0;
      endcase
      if (pend) begin
        r0 = '{token_class: cls, start_offset: tstart, token_length: cnt, last: 1'b0};
        n  = 2'd1;
      end
      state_next = S_START;
      cnt_next   = 8'd0;
    end else begin
      pos_next = pos + 32'd1;
      case (state)
        S_PLUS: begin
          if (dig) begin do_add = 1'b1; state_next = S_INT; end
          else begin do_close = 1'b1; cls = CLS_PLUS; end
        end
        S_SLASH: begin
          if (b == "/") begin state_next = S_LCOM; cnt_next = 8'd0; end
          else if (b == "*") begin state_next = S_BCOM; cnt_next = 8'd0; end
          else begin do_close = 1'b1; cls = CLS_SLASH; end
        end
        S_LT: begin
          if (b == "=") begin do_add_emit = 1'b1; cls = CLS_LE; end
          else begin do_close = 1'b1; cls = CLS_LT; end
        end
        S_GT: begin
          if (b == "=") begin do_add_emit = 1'b1; cls = CLS_GE; end
          else begin do_close = 1'b1; cls = CLS_GT; end
        end
        S_EQ: begin
          if (b == "=") begin do_add_emit = 1'b1; cls = CLS_EQ; end
          else begin do_close = 1'b1; cls = CLS_ASSIGN; end
        end
        S_BANG: begin
          if (b == "=") begin do_add_emit = 1'b1; cls = CLS_NE; end
          else if (term) begin do_close = 1'b1; cls = CLS_ERR; end
          else begin do_add = 1'b1; state_next = S_SKIP; end
        end
        S_STR: begin
          if (b == 8'h22) begin do_add_emit = 1'b1; cls = CLS_STR; end
          else do_add = 1'b1;
        end
        S_ID: begin
          if (is_letter(b) || dig) do_add = 1'b1;
          else begin do_close = 1'b1; cls = word_class(wc, cnt); end
        end
        S_INT: begin
          if (dig) do_add = 1'b1;
          else if (b == ".") begin do_add = 1'b1; state_next = S_FRAC; end
          else begin do_close = 1'b1; cls = CLS_NUM; end
        end
        S_FRAC: begin
          if (dig) do_add = 1'b1;
          else if (b == "e") begin do_add = 1'b1; state_next = S_EXP; end
          else begin do_close = 1'b1; cls = CLS_DBL; end
        end
        S_EXP: begin
          if (dig) begin do_add = 1'b1; state_next = S_EXPDIG; end
          else if (b == "-") begin do_add = 1'b1; state_next = S_EXPSIGN; end
          else if (term) begin do_close = 1'b1; cls = CLS_ERR; end
          else begin do_add = 1'b1; state_next = S_SKIP; end
        end
        S_EXPSIGN: begin
          if (dig) begin do_add = 1'b1; state_next = S_EXPDIG; end
          else if (term) begin do_close = 1'b1; cls = CLS_ERR; end
          else begin do_add = 1'b1; state_next = S_SKIP; end
        end
        S_EXPDIG: begin
          if (dig) do_add = 1'b1;
          else begin do_close = 1'b1; cls = CLS_DBL; end
        end
        S_LCOM: begin
          if (b == 8'h0a) state_next = S_START;
        end
        S_BCOM: begin
          if (b == "*") state_next = S_BCOMSTAR;
        end
        S_BCOMSTAR: begin
          if (b == "/") state_next = S_START;
          else if (b != "*") state_next = S_BCOM;
        end
        S_SKIP: begin
          if (term) begin do_close = 1'b1; cls = CLS_ERR; end
          else do_add = 1'b1;
        end
        default: do_restart = 1'b1;
      endcase

      // append the character to the current token
      if (do_add || do_add_emit) begin
        cnt_next = cnt_add;
        if (cnt < 8'(KW_CHARS)) begin
          wc_next[cnt[WC_IDX_W-1:0]] = b;
        end
      end

      // token closed by this character, character included
      if (do_add_emit) begin
        r0 = '{token_class: cls, start_offset: tstart, token_length: cnt_add, last: 1'b0};
        n  = 2'd1;
        state_next = S_START;
        cnt_next   = 8'd0;
      end

      // token closed before this character, which is then scanned afresh
      if (do_close) begin
        r0 = '{token_class: cls, start_offset: tstart, token_length: cnt, last: 1'b0};
        n  = 2'd1;
        do_restart = 1'b1;
      end

      // open a new token from the start state
      if (do_restart) begin
        if (blank) begin
          state_next = S_START;
          cnt_next   = 8'd0;
        end else if (is_single) begin
          tstart_next = pos;
          state_next  = S_START;
          cnt_next    = 8'd0;
          if (n == 2'd0) begin
            r0 = '{token_class: single_cls, start_offset: pos, token_length: 8'd1,
                   last: 1'b0};
          end else begin
            r1 = '{token_class: single_cls, start_offset: pos, token_length: 8'd1,
                   last: 1'b0};
          end
          n = n + 2'd1;
        end else begin
          tstart_next = pos;
          cnt_next    = 8'd1;
          wc_next[0]  = b;
          state_next  = start_state;
        end
      end
    end

    // mark the final result of this item
    if (n == 2'd1) begin
      r0.last = 1'b1;
    end else if (n == 2'd2) begin
      r1.last = 1'b1;
    end
  end

  assign res = '{count: take ? n : 2'd0, first: r0, second: r1};

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_START;
      pos    <= '0;
      tstart <= '0;
      cnt    <= '0;
    end else if (take) begin
      state  <= state_next;
      pos    <= pos_next;
      tstart <= tstart_next;
      cnt    <= cnt_next;
    end
  end

  // leading characters of the token
  always_ff @(posedge clk) begin
    if (take) begin
      wc <= wc_next;
    end
  end

  // a flush always leaves the scanner idle with an empty token
  a_flush_idle: assert property (@(posedge clk) disable iff (rst)
    take && item.kind |=> (state == S_START) && (cnt == 8'd0))
    else $error("scanner not idle after flush");

  // the offset counts characters only
  a_pos_count: assert property (@(posedge clk) disable iff (rst)
    take |=> pos == ($past(pos) + {31'd0, !$past(item.kind)}))
    else $error("byte position miscounted");

  // characters inside a line comment produce no token
  a_comment_quiet: assert property (@(posedge clk) disable iff (rst)
    take && !item.kind && (state == S_LCOM) |-> res.count == 2'd0)
    else $error("token emitted inside comment");

endmodule

// ===== rtl/cmts_rq.sv =====
`timescale 1ns / 1ps
// Result queue: takes up to two token results per cycle, hands out one per transfer.
// Depends on cmts_pkg.
module cmts_rq (
  input  logic                  clk,
  input  logic                  rst,
  input  cmts_pkg::scan_res_t   push,
  output logic                  busy,
  output logic                  token_valid,
  input  logic                  token_stall,
  output cmts_pkg::token_item_t token_data
);
  import cmts_pkg::*;

  localparam int PTR_W = $clog2(RQ_DEPTH);
  localparam int CNT_W = $clog2(RQ_DEPTH + 1);

  token_item_t       mem [RQ_DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_W-1:0]  fill, fill_next;
  logic              pop;

  assign pop         = token_valid && !token_stall;
  assign token_valid = (fill != '0);
  assign token_data  = mem[rd_ptr];
  // room for the two results one item may bring
  assign busy        = (fill > CNT_W'(RQ_DEPTH - 2));
  assign fill_next   = fill + CNT_W'(push.count) - CNT_W'(pop);

  // storage
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr + PTR_W'(1)] <= push.second;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push.count);
      rd_ptr <= rd_ptr + PTR_W'(pop);
      fill   <= fill_next;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(RQ_DEPTH))
    else $error("result queue overflow");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (push.count != 2'd0) |-> !busy)
    else $error("results pushed without room");

  a_push_shows: assert property (@(posedge clk) disable iff (rst)
    (push.count != 2'd0) |=> token_valid)
    else $error("pushed result not presented");

endmodule

// ===== rtl/c_minus_token_scanner_unit.sv =====
`timescale 1ns / 1ps
// Token scanner for C-minus source text, top level.
// Depends on cmts_pkg, cmts_scan and cmts_rq.
//
// Input channel char_valid / char_stall / char_data carries one item per
// transfer: a source byte (kind 0) or an end-of-input flush (kind 1).
// Output channel token_valid / token_stall / token_data carries one token
// per transfer: class, start offset, saturated length and a last flag that
// marks the final token caused by one input item.
// Each byte is scanned in the cycle it is accepted; its tokens are queued
// and can be presented on the next cycle. One input item is accepted
// every cycle while the four-entry result queue has room for two more
// tokens; a byte that closes one token and forms a one-byte token of its
// own yields two output transfers.
// When the receiver stalls, queued tokens hold and char_stall rises once
// fewer than two entries are free. Synchronous reset empties the queue and
// returns the scanner to its start state with offset zero.
module c_minus_token_scanner_unit #(
  parameter int MAX_TOKEN_LEN = 255
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  char_valid,
  output logic                  char_stall,
  input  cmts_pkg::char_item_t  char_data,
  output logic                  token_valid,
  input  logic                  token_stall,
  output cmts_pkg::token_item_t token_data
);
  import cmts_pkg::*;

  logic      take;
  logic      busy;
  scan_res_t res;

  // input transfer
  assign char_stall = busy;
  assign take       = char_valid && !busy;

  cmts_scan #(
    .MAX_TOKEN_LEN(MAX_TOKEN_LEN)
  ) u_scan (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .item (char_data),
    .res  (res)
  );

  cmts_rq u_rq (
    .clk         (clk),
    .rst         (rst),
    .push        (res),
    .busy        (busy),
    .token_valid (token_valid),
    .token_stall (token_stall),
    .token_data  (token_data)
  );

endmodule

// ===== bench/tb_c_minus_token_scanner_unit.sv =====
`timescale 1ns / 1ps
// Self-checking bench for c_minus_token_scanner_unit: directed rows, then lexeme streams.
// Depends on cmts_pkg and the scanner RTL; an in-bench scanner predicts every token.
module tb_c_minus_token_scanner_unit;
  import cmts_pkg::*;

  localparam int          CYCLE_LIMIT = 600000;
  localparam int          HEAD_CHARS  = 6;
  localparam int          LEN_CAP     = 255;
  localparam logic        K_BYTE      = 1'b0;
  localparam logic        K_FLUSH     = 1'b1;
  localparam logic [7:0]  CH_TAB      = 8'h09;
  localparam logic [7:0]  CH_NL       = 8'h0a;
  localparam logic [4:0]  CLS_IF      = 5'd0;
  localparam int          NO_LONG     = 0;
  localparam int          LONG_WORD   = 1;
  localparam int          LONG_NUMBER = 2;

  // scanner states of the predictor
  typedef enum logic [4:0] {
    SC_IDLE, SC_PLUS, SC_SLASH, SC_LT, SC_GT, SC_EQ, SC_BANG, SC_STR, SC_WORD, SC_INT,
    SC_FRAC, SC_EXP, SC_EXP_SIGN, SC_EXP_DIG, SC_LINE_CMT, SC_BLOCK_CMT, SC_BLOCK_STAR,
    SC_SKIP
  } scan_st_t;

  // one directed row; fixed rows carry their token as written
  typedef struct packed {
    logic        kind;
    logic [7:0]  ch;
    logic        fixed;
    logic [4:0]  cls;
    logic [31:0] off;
    logic [7:0]  len;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        char_valid = 1'b0;
  logic        char_stall;
  char_item_t  char_data = '0;
  logic        token_valid;
  logic        token_stall = 1'b0;
  token_item_t token_data;

  c_minus_token_scanner_unit dut (
    .clk         (clk),
    .rst         (rst),
    .char_valid  (char_valid),
    .char_stall  (char_stall),
    .char_data   (char_data),
    .token_valid (token_valid),
    .token_stall (token_stall),
    .token_data  (token_data)
  );

  always #6 clk = ~clk;

  // predictor state
  scan_st_t    sc_state = SC_IDLE;
  logic [31:0] sc_pos = '0;
  logic [31:0] sc_start = '0;
  logic [7:0]  sc_len = '0;
  logic [7:0]  sc_head [HEAD_CHARS] = '{default: 8'h00};
  token_item_t step_tokens [$];
  token_item_t tokens_due [$];
  char_item_t  source_items [$];

  string kw_words [8] = '{"if", "else", "int", "double", "return", "void", "while", "char"};

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int tokens_checked = 0;
  int bytes_sent = 0;
  int flushes_sent = 0;
  int cycle_count = 0;
  token_item_t got_tok;
  token_item_t want_tok;

  // directed rows, offsets count source bytes only
  row_t directed_rows [27] = '{
    '{K_BYTE,  ";",   1'b1, CLS_SEMI, 32'd0,  8'd1},  // one-byte token right after reset
    '{K_BYTE,  8'hff, 1'b0, 5'd0,     32'd0,  8'd0},  // top byte opens an error
    '{K_BYTE,  8'h00, 1'b0, 5'd0,     32'd0,  8'd0},
    '{K_BYTE,  " ",   1'b1, CLS_ERR,  32'd1,  8'd2},  // blank ends the error
    '{K_BYTE,  "!",   1'b0, 5'd0,     32'd0,  8'd0},  // lone bang
    '{K_BYTE,  "x",   1'b0, 5'd0,     32'd0,  8'd0},
    '{K_BYTE,  ";",   1'b0, 5'd0,     32'd0,  8'd0},  // error plus semicolon
    '{K_BYTE,  "+",   1'b0, 5'd0,     32'd0,  8'd0},  // signed double with exponent
    '{K_BYTE,  "5",   1'b0, 5'd0,     32'd0,  8'd0},
    '{K_BYTE,  ".",   1'b0, 5'd0,     32'd0,  8'd0},
    '{K_BYTE,  "e",   1'b0, 5'd0,     32'd0,  8'd0},
    '{K_BYTE,  "-",   1'b0, 5'd0,     32'd0,  8'd0},
    '{K_BYTE,  "7",   1'b0, 5'd0,     32'd0,  8'd0},
    '{K_BYTE,  "<",   1'b0, 5'd0,     32'd0,  8'd0},
    '{K_BYTE,  "=",   1'b1, CLS_LE,   32'd13, 8'd2},
    '{K_BYTE,  "/",   1'b0, 5'd0,     32'd0,  8'd0},  // block comment with a star run
    '{K_BYTE,  "*",   1'b0, 5'd0,     32'd0,  8'd0},
    '{K_BYTE,  "*",   1'b0, 5'd0,     32'd0,  8'd0},
    '{K_BYTE,  "*",   1'b0, 5'd0,     32'd0,  8'd0},
    '{K_BYTE,  "/",   1'b0, 5'd0,     32'd0,  8'd0},
    '{K_BYTE,  "\"",  1'b0, 5'd0,     32'd0,  8'd0},  // unterminated string
    '{K_BYTE,  "a",   1'b0, 5'd0,     32'd0,  8'd0},
    '{K_FLUSH, 8'ha5, 1'b1, CLS_ERR,  32'd20, 8'd2},
    '{K_BYTE,  "i",   1'b0, 5'd0,     32'd0,  8'd0},
    '{K_BYTE,  "f",   1'b0, 5'd0,     32'd0,  8'd0},
    '{K_FLUSH, 8'h5a, 1'b1, CLS_IF,   32'd22, 8'd2},
    '{K_FLUSH, 8'h00, 1'b0, 5'd0,     32'd0,  8'd0}   // flush with nothing pending
  };

  // character classes
  function automatic logic digit_ch(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic letter_ch(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic logic space_ch(input logic [7:0] b);
    return b == " " || b == CH_TAB || b == CH_NL;
  endfunction

  function automatic logic stop_ch(input logic [7:0] b);
    return space_ch(b) || b == ";";
  endfunction

  // token bookkeeping
  function automatic void close_token(input logic [4:0] cls);
    token_item_t t;
    t.token_class  = cls;
    t.start_offset = sc_start;
    t.token_length = sc_len;
    t.last         = 1'b0;
    step_tokens.push_back(t);
    sc_state = SC_IDLE;
    sc_len   = '0;
  endfunction

  function automatic void grow_token(input logic [7:0] b);
    if (sc_len < HEAD_CHARS) sc_head[int'(sc_len)] = b;
    if (sc_len < LEN_CAP) sc_len = sc_len + 8'd1;
  endfunction

  // reserved word only when the whole text matches
  function automatic logic [4:0] word_or_id();
    logic [4:0] cls;
    bit         same;
    cls = CLS_ID;
    for (int k = 0; k < 8; k++) begin
      same = (int'(sc_len) == kw_words[k].len());
      for (int i = 0; same && i < kw_words[k].len(); i++) same = (sc_head[i] == kw_words[k][i]);
      if (same) cls = 5'(k);
    end
    return cls;
  endfunction

  function automatic void begin_token(input logic [7:0] b);
    if (space_ch(b)) return;
    sc_start = sc_pos;
    sc_len   = '0;
    grow_token(b);
    case (b)
      "+": sc_state = SC_PLUS;
      "/": sc_state = SC_SLASH;
      "<": sc_state = SC_LT;
      ">": sc_state = SC_GT;
      "=": sc_state = SC_EQ;
      "!": sc_state = SC_BANG;
      "\"": sc_state = SC_STR;
      "-": close_token(CLS_MINUS);
      "*": close_token(CLS_STAR);
      ";": close_token(CLS_SEMI);
      ",": close_token(CLS_COMMA);
      "[": close_token(CLS_LBRK);
      "]": close_token(CLS_RBRK);
      "(": close_token(CLS_LPAR);
      ")": close_token(CLS_RPAR);
      "{": close_token(CLS_LBRC);
      "}": close_token(CLS_RBRC);
      default: begin
        if (letter_ch(b)) sc_state = SC_WORD;
        else if (digit_ch(b)) sc_state = SC_INT;
        else sc_state = SC_SKIP;
      end
    endcase
  endfunction

  // error skip, a terminator closes the error and is scanned again
  function automatic void skip_err(input logic [7:0] b);
    sc_state = SC_SKIP;
    if (stop_ch(b)) begin
      close_token(CLS_ERR);
      begin_token(b);
    end else begin
      grow_token(b);
    end
  endfunction

  function automatic void pair_op(input logic [7:0] b, input logic [4:0] two,
                                  input logic [4:0] one);
    if (b == "=") begin
      grow_token(b);
      close_token(two);
    end else begin
      close_token(one);
      begin_token(b);
    end
  endfunction

  function automatic void scan_byte(input logic [7:0] b);
    case (sc_state)
      SC_PLUS: begin
        if (digit_ch(b)) begin
          grow_token(b);
          sc_state = SC_INT;
        end else begin
          close_token(CLS_PLUS);
          begin_token(b);
        end
      end
      SC_SLASH: begin
        if (b == "/") begin
          sc_state = SC_LINE_CMT;
          sc_len = '0;
        end else if (b == "*") begin
          sc_state = SC_BLOCK_CMT;
          sc_len = '0;
        end else begin
          close_token(CLS_SLASH);
          begin_token(b);
        end
      end
      SC_LT: pair_op(b, CLS_LE, CLS_LT);
      SC_GT: pair_op(b, CLS_GE, CLS_GT);
      SC_EQ: pair_op(b, CLS_EQ, CLS_ASSIGN);
      SC_BANG: begin
        if (b == "=") begin
          grow_token(b);
          close_token(CLS_NE);
        end else begin
          skip_err(b);
        end
      end
      SC_STR: begin
        grow_token(b);
        if (b == "\"") close_token(CLS_STR);
      end
      SC_WORD: begin
        if (letter_ch(b) || digit_ch(b)) begin
          grow_token(b);
        end else begin
          close_token(word_or_id());
          begin_token(b);
        end
      end
      SC_INT: begin
        if (digit_ch(b)) begin
          grow_token(b);
        end else if (b == ".") begin
          grow_token(b);
          sc_state = SC_FRAC;
        end else begin
          close_token(CLS_NUM);
          begin_token(b);
        end
      end
      SC_FRAC: begin
        if (digit_ch(b)) begin
          grow_token(b);
        end else if (b == "e") begin
          grow_token(b);
          sc_state = SC_EXP;
        end else begin
          close_token(CLS_DBL);
          begin_token(b);
        end
      end
      SC_EXP: begin
        if (digit_ch(b)) begin
          grow_token(b);
          sc_state = SC_EXP_DIG;
        end else if (b == "-") begin
          grow_token(b);
          sc_state = SC_EXP_SIGN;
        end else begin
          skip_err(b);
        end
      end
      SC_EXP_SIGN: begin
        if (digit_ch(b)) begin
          grow_token(b);
          sc_state = SC_EXP_DIG;
        end else begin
          skip_err(b);
        end
      end
      SC_EXP_DIG: begin
        if (digit_ch(b)) begin
          grow_token(b);
        end else begin
          close_token(CLS_DBL);
          begin_token(b);
        end
      end
      SC_LINE_CMT: begin
        if (b == CH_NL) sc_state = SC_IDLE;
      end
      SC_BLOCK_CMT: begin
        if (b == "*") sc_state = SC_BLOCK_STAR;
      end
      SC_BLOCK_STAR: begin
        if (b == "/") sc_state = SC_IDLE;
        else if (b != "*") sc_state = SC_BLOCK_CMT;
      end
      SC_SKIP: skip_err(b);
      default: begin
        sc_state = SC_IDLE;
        begin_token(b);
      end
    endcase
  endfunction

  // end of input, pending token goes out with its current class, unfinished ones as errors
  function automatic void flush_pending();
    case (sc_state)
      SC_PLUS: close_token(CLS_PLUS);
      SC_SLASH: close_token(CLS_SLASH);
      SC_LT: close_token(CLS_LT);
      SC_GT: close_token(CLS_GT);
      SC_EQ: close_token(CLS_ASSIGN);
      SC_WORD: close_token(word_or_id());
      SC_INT: close_token(CLS_NUM);
      SC_FRAC, SC_EXP_DIG: close_token(CLS_DBL);
      SC_BANG, SC_STR, SC_EXP, SC_EXP_SIGN, SC_SKIP: close_token(CLS_ERR);
      default: ;
    endcase
    sc_state = SC_IDLE;
    sc_len   = '0;
  endfunction

  // tokens caused by one accepted item
  function automatic void scan_source_item(input char_item_t it);
    token_item_t t;
    step_tokens.delete();
    if (it.kind == K_FLUSH) begin
      flush_pending();
    end else begin
      scan_byte(it.byte_value);
      sc_pos = sc_pos + 32'd1;
    end
    if (step_tokens.size() > 0) begin
      t = step_tokens[step_tokens.size() - 1];
      t.last = 1'b1;
      step_tokens[step_tokens.size() - 1] = t;
    end
  endfunction

  // stimulus builders
  function automatic void put_byte(input logic [7:0] b);
    char_item_t c;
    c.kind = K_BYTE;
    c.byte_value = b;
    source_items.push_back(c);
  endfunction

  function automatic void put_flush();
    char_item_t c;
    c.kind = K_FLUSH;
    c.byte_value = 8'($urandom_range(255));
    source_items.push_back(c);
  endfunction

  function automatic void put_text(input string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endfunction

  function automatic logic [7:0] pick_letter();
    logic [7:0] b;
    b = 8'("a" + $urandom_range(25));
    if ($urandom_range(3) == 0) b = b - 8'h20;
    return b;
  endfunction

  function automatic logic [7:0] pick_digit();
    return 8'("0" + $urandom_range(9));
  endfunction

  function automatic logic [7:0] pick_alnum();
    return ($urandom_range(3) == 0) ? pick_digit() : pick_letter();
  endfunction

  function automatic void put_digits(input int n);
    repeat (n) put_byte(pick_digit());
  endfunction

  function automatic void put_gap();
    case ($urandom_range(7))
      0, 1, 2: put_byte(" ");
      3: put_byte(CH_TAB);
      4: put_byte(CH_NL);
      5: put_byte(";");
      default: ;  // adjacent tokens
    endcase
  endfunction

  // one lexeme, mostly well formed, then an optional separator
  function automatic void put_lexeme();
    string       w;
    string       ops;
    logic [7:0]  b;
    bit          star;
    ops = "-*;,[](){}+/<>=";
    case ($urandom_range(14))
      0: put_text(kw_words[$urandom_range(7)]);
      1: begin
        // near misses of reserved words
        w = kw_words[$urandom_range(7)];
        case ($urandom_range(2))
          0: put_text(w.substr(0, w.len() - 2));
          1: begin
            put_text(w);
            put_byte(pick_alnum());
          end
          default: begin
            put_byte(w[0] - 8'h20);
            put_text(w.substr(1, w.len() - 1));
          end
        endcase
      end
      2: begin
        put_byte(pick_letter());
        repeat ($urandom_range(9)) put_byte(pick_alnum());
      end
      3: begin
        if ($urandom_range(1)) put_byte("+");
        put_digits($urandom_range(1, 6));
      end
      4: begin
        put_digits($urandom_range(1, 4));
        put_byte(".");
        put_digits($urandom_range(3));
        if ($urandom_range(1)) begin
          put_byte("e");
          if ($urandom_range(1)) put_byte("-");
          put_digits($urandom_range(1, 3));
        end
      end
      5: begin
        // exponent without digits
        put_digits($urandom_range(1, 3));
        put_byte(".");
        put_digits($urandom_range(2));
        put_byte("e");
        if ($urandom_range(1)) put_byte("-");
        b = 8'($urandom_range(255));
        if (digit_ch(b) || b == "-") b = "x";
        put_byte(b);
        repeat ($urandom_range(2)) put_byte(pick_alnum());
      end
      6: begin
        put_byte("\"");
        repeat ($urandom_range(6)) begin
          b = 8'($urandom_range(255));
          if (b == "\"") b = "q";
          put_byte(b);
        end
        put_byte("\"");
      end
      7: put_byte(ops[$urandom_range(ops.len() - 1)]);
      8: begin
        case ($urandom_range(3))
          0: put_text("<=");
          1: put_text(">=");
          2: put_text("==");
          default: put_text("!=");
        endcase
      end
      9: begin
        put_byte("!");
        b = 8'($urandom_range(255));
        if (b == "=") b = "#";
        put_byte(b);
      end
      10: begin
        put_text("//");
        repeat ($urandom_range(8)) begin
          b = 8'($urandom_range(255));
          if (b == CH_NL) b = "n";
          put_byte(b);
        end
        put_byte(CH_NL);
      end
      11: begin
        put_text("/*");
        star = 1'b0;
        repeat ($urandom_range(8)) begin
          b = ($urandom_range(3) == 0) ? 8'("*") : 8'($urandom_range(255));
          if (star && b == "/") b = "a";
          star = (b == "*");
          put_byte(b);
        end
        repeat ($urandom_range(1, 3)) put_byte("*");
        put_byte("/");
      end
      12: repeat ($urandom_range(1, 3)) put_byte(8'($urandom_range(255)));
      13: begin
        // token cut short by end of input
        case ($urandom_range(5))
          0: begin
            put_byte("\"");
            repeat ($urandom_range(3)) put_byte(pick_letter());
          end
          1: begin
            put_digits($urandom_range(1, 2));
            put_text(".5e");
            if ($urandom_range(1)) put_byte("-");
          end
          2: put_byte("!");
          3: begin
            put_text("/*");
            repeat ($urandom_range(3)) put_byte(pick_letter());
          end
          4: begin
            put_byte(pick_letter());
            repeat ($urandom_range(4)) put_byte(pick_alnum());
          end
          default: put_byte(ops[10 + $urandom_range(4)]);
        endcase
        put_flush();
        return;
      end
      default: put_flush();
    endcase
    put_gap();
  endfunction

  // one transfer on the input channel, then its tokens join the queue
  task automatic send_item(input char_item_t it, input logic use_fixed,
                           input token_item_t fixed_tok);
    while ($urandom_range(99) < send_idle_pct) begin
      char_valid <= 1'b0;
      @(negedge clk);
    end
    char_valid <= 1'b1;
    char_data  <= it;
    @(posedge clk);
    while (char_stall) @(posedge clk);
    scan_source_item(it);
    if (use_fixed) tokens_due.push_back(fixed_tok);
    else foreach (step_tokens[j]) tokens_due.push_back(step_tokens[j]);
    if (it.kind == K_FLUSH) flushes_sent++;
    else bytes_sent++;
    @(negedge clk);
  endtask

  // hold the sender until every predicted token is out
  task automatic drain_tokens();
    char_valid <= 1'b0;
    @(negedge clk);
    while (tokens_due.size() != 0) @(negedge clk);
  endtask

  task automatic run_phase(input int snd_pct, input int rcv_pct, input int count,
                           input int long_sel);
    send_idle_pct  = snd_pct;
    recv_stall_pct = rcv_pct;
    source_items.delete();
    if (long_sel == LONG_WORD) begin
      put_byte(pick_letter());
      repeat (262) put_byte(pick_alnum());
      put_gap();
    end else if (long_sel == LONG_NUMBER) begin
      put_byte("+");
      put_digits(258);
      put_gap();
    end
    while (source_items.size() < count) put_lexeme();
    while (source_items.size() != 0) begin
      send_item(source_items.pop_front(), 1'b0, '0);
      if ($urandom_range(199) == 0) drain_tokens();
    end
    drain_tokens();
  endtask

  // receiver stall
  always @(negedge clk) begin
    token_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  function automatic void report_mismatch(input string what, input token_item_t want,
                                          input token_item_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display({"%0t %s: expected class %0d start %0d len %0d last %0b,",
                " got class %0d start %0d len %0d last %0b"},
               $realtime, what, want.token_class, want.start_offset, want.token_length,
               want.last, got.token_class, got.start_offset, got.token_length, got.last);
    end
  endfunction

  // output transfers against the oldest prediction
  always @(posedge clk) begin
    if (!rst && token_valid === 1'b1 && token_stall === 1'b0) begin
      got_tok = token_data;
      tokens_checked++;
      if (tokens_due.size() == 0) begin
        report_mismatch("token with nothing expected", '0, got_tok);
      end else begin
        want_tok = tokens_due.pop_front();
        if (got_tok.token_class !== want_tok.token_class ||
            got_tok.start_offset !== want_tok.start_offset ||
            got_tok.token_length !== want_tok.token_length ||
            got_tok.last !== want_tok.last) begin
          report_mismatch("token mismatch", want_tok, got_tok);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d tokens still expected", cycle_count,
               tokens_due.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    char_item_t  it;
    token_item_t fixed_tok;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed rows
    foreach (directed_rows[i]) begin
      it.kind       = directed_rows[i].kind;
      it.byte_value = directed_rows[i].ch;
      fixed_tok.token_class  = directed_rows[i].cls;
      fixed_tok.start_offset = directed_rows[i].off;
      fixed_tok.token_length = directed_rows[i].len;
      fixed_tok.last         = 1'b1;
      send_item(it, directed_rows[i].fixed, fixed_tok);
    end
    drain_tokens();

    // random lexeme streams under three idle profiles
    run_phase(6, 88, 470, LONG_WORD);
    run_phase(88, 6, 470, LONG_NUMBER);
    run_phase(0, 0, 470, NO_LONG);

    repeat (8) @(posedge clk);
    $display("scanned %0d source bytes and %0d end-of-input marks, %0d tokens checked",
             bytes_sent, flushes_sent, tokens_checked);
    $display("covered reserved words, operators, numbers, strings, comments, errors, long tokens");
    if (mismatches == 0 && tokens_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches, %0d tokens never seen", mismatches, tokens_due.size());
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/cmts_pkg.sv
rtl/cmts_scan.sv
rtl/cmts_rq.sv
rtl/c_minus_token_scanner_unit.sv
bench/tb_c_minus_token_scanner_unit.sv
